@@ hw/rtl/plus_stencil_torus_blur_defines.svh @@
// Assertion macros used by the checker file.
`ifndef PLUS_STENCIL_TORUS_BLUR_DEFINES_SVH
`define PLUS_STENCIL_TORUS_BLUR_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define PSTB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pstb check failed");

// Next-cycle implication, masked while reset is high.
`define PSTB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pstb check failed");

`endif

@@ hw/rtl/pstb_pkg.sv @@
package pstb_pkg;

   // Width of a five-tap channel sum (at most 1275)
   localparam int SUM_W = 11;

   // Opcodes of the input word
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FILTER = 2'd1;
   localparam logic [1:0] OP_SWAP   = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] col_out;
      logic [7:0] row_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // Control from the sequencer to the averaging datapath
   typedef struct packed {
      logic clear;
      logic add;
      logic divide;
   } avg_ctrl_type;

endpackage

@@ hw/rtl/pstb_frame_mem.sv @@
module pstb_frame_mem #(
   parameter int ADDR_W = 17
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   addr,
   input  pstb_pkg::pixel_type wr_data,
   output pstb_pkg::pixel_type rd_data
);
   import pstb_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   pixel_type ram_ff [DEPTH];
   pixel_type rd_data_ff;

   // Single port: write, or a registered read whose data follows in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[addr] <= wr_data;
      end else begin
         rd_data_ff <= ram_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pstb_avg.sv @@
module pstb_avg (
   input  logic                   clock,
   input  pstb_pkg::avg_ctrl_type ctrl,
   input  pstb_pkg::pixel_type    tap,
   output pstb_pkg::pixel_type    avg
);
   import pstb_pkg::*;

   // Divide by five as multiply by 3277 / 2^14, exact for sums up to 1275
   localparam int DIV5_MUL   = 3277;
   localparam int DIV5_SHIFT = 14;
   localparam int PROD_W     = SUM_W + 12;

   function automatic logic [7:0] div_by5(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(s) * PROD_W'(DIV5_MUL);
      return prod[DIV5_SHIFT +: 8];
   endfunction

   logic [SUM_W-1:0] red_sum_ff, green_sum_ff, blue_sum_ff;
   logic [SUM_W-1:0] red_sum_in, green_sum_in, blue_sum_in;
   pixel_type        avg_ff;

   // Clear at the start of a pixel, add each tap as it leaves the memory
   always_comb begin
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in  = blue_sum_ff;
      if (ctrl.clear) begin
         red_sum_in   = '0;
         green_sum_in = '0;
         blue_sum_in  = '0;
      end else if (ctrl.add) begin
         red_sum_in   = red_sum_ff + SUM_W'(tap.red);
         green_sum_in = green_sum_ff + SUM_W'(tap.green);
         blue_sum_in  = blue_sum_ff + SUM_W'(tap.blue);
      end
   end

   always_ff @(posedge clock) begin
      red_sum_ff   <= red_sum_in;
      green_sum_ff <= green_sum_in;
      blue_sum_ff  <= blue_sum_in;
      if (ctrl.divide) begin
         avg_ff.red   <= div_by5(red_sum_ff);
         avg_ff.green <= div_by5(green_sum_ff);
         avg_ff.blue  <= div_by5(blue_sum_ff);
      end
   end

   assign avg = avg_ff;

endmodule

@@ hw/rtl/plus_stencil_torus_blur.sv @@
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_ready  req_data (opcode, col, row, colour)
// rsp       out        rsp_valid / rsp_ready  rsp_data (col, row, averaged colour)
//
// One word at a time. A filter makes five serial
// reads of the single-port frame memory, then sum, divide, write-back and emit.
// A filter waits in its emit step while an earlier result is still held in rsp.
// Reset makes frame zero current; frame contents are undefined until loaded,
// and there is no clearing pass.
module plus_stencil_torus_blur #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pstb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pstb_pkg::rsp_type rsp_data
);
   import pstb_pkg::*;

   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int PIX_W  = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
   localparam int ADDR_W = PIX_W + 1;
   localparam int LAST_TAP = 4;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_SUM   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   logic         side_ff, side_in;
   logic [2:0]   tap_ff, tap_in;
   logic         rd_pend_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;

   logic [XW-1:0] x_ff, xl_ff, xr_ff;
   logic [YW-1:0] y_ff, yu_ff, yd_ff;
   logic [7:0]    col_ff, row_ff;
   pixel_type     load_px_ff;

   logic          accept, in_range, emit_fire;
   logic [XW-1:0] req_x, req_xl, req_xr, tap_x;
   logic [YW-1:0] req_y, req_yu, req_yd, tap_y;
   logic [PIX_W-1:0] tap_pix, centre_pix;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_addr;
   pixel_type         mem_wr_data, mem_rd_data;
   pixel_type         avg_px;
   avg_ctrl_type      avg_ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_data.col) < FRAME_WIDTH)
                   && (int'(req_data.row) < FRAME_HEIGHT);

   // Wrap the neighbours of the incoming position round the torus
   always_comb begin
      req_x  = XW'(req_data.col);
      req_y  = YW'(req_data.row);
      req_xl = (req_x == '0) ? XW'(FRAME_WIDTH - 1) : req_x - XW'(1);
      req_xr = (req_x == XW'(FRAME_WIDTH - 1)) ? '0 : req_x + XW'(1);
      req_yu = (req_y == '0) ? YW'(FRAME_HEIGHT - 1) : req_y - YW'(1);
      req_yd = (req_y == YW'(FRAME_HEIGHT - 1)) ? '0 : req_y + YW'(1);
   end

   // Capture the word on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= req_x;
         xl_ff      <= req_xl;
         xr_ff      <= req_xr;
         y_ff       <= req_y;
         yu_ff      <= req_yu;
         yd_ff      <= req_yd;
         col_ff     <= req_data.col;
         row_ff     <= req_data.row;
         load_px_ff <= '{red: req_data.red_in, green: req_data.green_in,
                         blue: req_data.blue_in};
      end
   end

   // Pick the tap position being read
   always_comb begin
      case (tap_ff)
         3'd1:    begin tap_x = xl_ff; tap_y = y_ff;  end
         3'd2:    begin tap_x = xr_ff; tap_y = y_ff;  end
         3'd3:    begin tap_x = x_ff;  tap_y = yu_ff; end
         3'd4:    begin tap_x = x_ff;  tap_y = yd_ff; end
         default: begin tap_x = x_ff;  tap_y = y_ff;  end
      endcase
      tap_pix    = PIX_W'(tap_y) * PIX_W'(FRAME_WIDTH) + PIX_W'(tap_x);
      centre_pix = PIX_W'(y_ff) * PIX_W'(FRAME_WIDTH) + PIX_W'(x_ff);
   end

   // Drive the frame memory: load into current frame, result into the other
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_addr    = {side_ff, tap_pix};
      mem_wr_data = load_px_ff;
      case (state_ff)
         ST_LOAD: begin
            mem_wr_en = 1'b1;
            mem_addr  = {side_ff, centre_pix};
         end
         ST_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_addr    = {~side_ff, centre_pix};
            mem_wr_data = avg_px;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Sequence the load, read, sum, divide, write-back and emit steps, and swap frames
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      tap_in   = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tap_in = '0;
               case (req_data.opcode)
                  OP_LOAD:   if (in_range) state_in = ST_LOAD;
                  OP_FILTER: if (in_range) state_in = ST_READ;
                  OP_SWAP:   side_in = ~side_ff;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:  state_in = ST_IDLE;
         ST_READ: begin
            if (tap_ff == 3'(LAST_TAP)) begin
               tap_in   = '0;
               state_in = ST_SUM;
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         ST_SUM:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_WRITE;
         ST_WRITE: state_in = ST_EMIT;
         ST_EMIT:  if (emit_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      avg_ctrl.clear  = accept && (req_data.opcode == OP_FILTER);
      avg_ctrl.add    = rd_pend_ff;
      avg_ctrl.divide = (state_ff == ST_DIV);
   end

   // Hold a result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         tap_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         tap_ff       <= tap_in;
         rd_pend_ff   <= (state_ff == ST_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_data_ff <= '{col_out: col_ff, row_out: row_ff, red_out: avg_px.red,
                          green_out: avg_px.green, blue_out: avg_px.blue};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pstb_frame_mem #(
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   pstb_avg u_avg (
      .clock (clock),
      .ctrl  (avg_ctrl),
      .tap   (mem_rd_data),
      .avg   (avg_px)
   );

endmodule

@@ hw/rtl/pstb_checker.sv @@
`include "plus_stencil_torus_blur_defines.svh"

module pstb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pstb_pkg::rsp_type rsp_data
);
   import pstb_pkg::*;

   // Leave reset ready for a word, with nothing pending on rsp
   `PSTB_ASSERT_NOW(a_reset_exit, $fell(reset), req_ready && !rsp_valid)

   // A word just taken cannot have produced a result yet
   `PSTB_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid))

   // Hold a stalled result
   `PSTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // Keep a stalled result unchanged
   `PSTB_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))

endmodule

bind plus_stencil_torus_blur pstb_checker u_pstb_checker (.*);

@@ sim/plus_stencil_torus_blur_tb.sv @@
`timescale 1ns / 100ps

module plus_stencil_torus_blur_tb;
   import pstb_pkg::*;

   localparam int FRAME_W     = 256;
   localparam int FRAME_H     = 256;
   localparam int PIXELS      = FRAME_W * FRAME_H;
   localparam int CLK_HALF    = 6;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 250;
   localparam int DRAIN_WAIT  = 24;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Shadow frames of the block, with a written flag per pixel
   logic [23:0] frame_pix   [2][PIXELS];
   bit          frame_known [2][PIXELS];
   bit          front_side;
   rsp_type     pending_averages [$];

   stim_row_type directed [24];

   int mismatches      = 0;
   int words_sent      = 0;
   int filters_sent    = 0;
   int swaps_sent      = 0;
   int results_checked = 0;
   int idle_cycles     = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_requests   = 0;
   int holds_served    = 0;

   plus_stencil_torus_blur i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // Index of stencil tap k around (col,row): centre, left, right, up, down, wrapped
   function automatic int tap_index(int col, int row, int k);
      int c;
      int r;
      c = col;
      r = row;
      case (k)
         1: c = (col == 0) ? FRAME_W - 1 : col - 1;
         2: c = (col == FRAME_W - 1) ? 0 : col + 1;
         3: r = (row == 0) ? FRAME_H - 1 : row - 1;
         4: r = (row == FRAME_H - 1) ? 0 : row + 1;
         default: ;
      endcase
      return r * FRAME_W + c;
   endfunction

   // Advance the shadow frames by one word and work out the averaged pixel, if any
   task automatic blur_predict(input req_type w, output bit emits, output rsp_type avg);
      logic [23:0]       taps [5];
      logic [SUM_W-1:0]  sum;
      logic [7:0]        chan [3];
      int                idx;
      emits = 1'b0;
      avg   = '0;
      idx   = tap_index(int'(w.col), int'(w.row), 0);
      case (w.opcode)
         OP_SWAP: front_side = !front_side;
         OP_LOAD: begin
            frame_pix[front_side][idx]   = {w.red_in, w.green_in, w.blue_in};
            frame_known[front_side][idx] = 1'b1;
         end
         OP_FILTER: begin
            for (int k = 0; k < 5; k++)
               taps[k] = frame_pix[front_side][tap_index(int'(w.col), int'(w.row), k)];
            for (int ch = 0; ch < 3; ch++) begin
               sum = '0;
               for (int k = 0; k < 5; k++)
                  sum = sum + SUM_W'(taps[k][8 * (2 - ch) +: 8]);
               chan[ch] = 8'(sum / 5);
            end
            avg.col_out   = w.col;
            avg.row_out   = w.row;
            avg.red_out   = chan[0];
            avg.green_out = chan[1];
            avg.blue_out  = chan[2];
            frame_pix[!front_side][idx]   = {chan[0], chan[1], chan[2]};
            frame_known[!front_side][idx] = 1'b1;
            emits = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch(name, 40'(got), 40'(want));
   endtask

   // Offer one word from a falling edge, hold it until taken, then predict
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      bit      emits;
      rsp_type avg;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      blur_predict(w, emits, avg);
      if (emits)
         pending_averages.push_back(typed ? want : avg);
      if (w.opcode != OP_UNUSED)
         words_sent++;
      if (w.opcode == OP_FILTER)
         filters_sent++;
      if (w.opcode == OP_SWAP)
         swaps_sent++;
      @(negedge clock);
   endtask

   // Mostly random levels, with the extremes weighted in
   function automatic logic [7:0] colour_level();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // Half the positions near the edges, so that wrapped taps come up often
   function automatic int pick_coord();
      int v;
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 255);
      v = $urandom_range(0, 7);
      return (v < 4) ? v : 248 + v;
   endfunction

   function automatic req_type make_word(logic [1:0] op, int col, int row);
      req_type w;
      w.opcode   = op;
      w.col      = 8'(col);
      w.row      = 8'(row);
      w.red_in   = colour_level();
      w.green_in = colour_level();
      w.blue_in  = colour_level();
      return w;
   endfunction

   // One random step: a well-formed filter with its loads, a stray load, a swap or noise
   task automatic random_step();
      int sel;
      int col;
      int row;
      int idx;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         col = pick_coord();
         row = pick_coord();
         for (int k = 0; k < 5; k++) begin
            idx = tap_index(col, row, k);
            if (!frame_known[front_side][idx] || $urandom_range(0, 9) == 0)
               send_word(make_word(OP_LOAD, idx % FRAME_W, idx / FRAME_W), 1'b0, '0);
         end
         send_word(make_word(OP_FILTER, col, row), 1'b0, '0);
      end else if (sel < 88) begin
         send_word(make_word(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255)),
                   1'b0, '0);
      end else if (sel < 95) begin
         send_word(make_word(OP_SWAP, $urandom_range(0, 255), $urandom_range(0, 255)),
                   1'b0, '0);
      end else begin
         send_word(make_word(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255)),
                   1'b0, '0);
      end
   endtask

   // Drive rsp_ready: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Compare each averaged pixel with the oldest one pending
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_averages.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_data, '0);
         end else begin
            want = pending_averages.pop_front();
            check_field("col_out", rsp_data.col_out, want.col_out);
            check_field("row_out", rsp_data.row_out, want.row_out);
            check_field("red_out", rsp_data.red_out, want.red_out);
            check_field("green_out", rsp_data.green_out, want.green_out);
            check_field("blue_out", rsp_data.blue_out, want.blue_out);
            results_checked++;
         end
      end
   end

   // Stop the run if no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[plus_stencil_torus_blur] ERROR");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      front_side = 1'b0;

      // Corner pixels, all-ones and all-zero neighbourhoods, unused opcode, both frames
      directed = '{
         '{'{OP_LOAD,   8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_LOAD,   8'd255, 8'd0,   8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_LOAD,   8'd1,   8'd0,   8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_LOAD,   8'd0,   8'd255, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_LOAD,   8'd0,   8'd1,   8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_FILTER, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00}, 1'b1,
           '{8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF}},
         '{'{OP_LOAD,   8'd255, 8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_LOAD,   8'd254, 8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_LOAD,   8'd0,   8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_LOAD,   8'd255, 8'd254, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_LOAD,   8'd255, 8'd0,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_FILTER, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
           '{8'd255, 8'd255, 8'h00, 8'h00, 8'h00}},
         '{'{OP_FILTER, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_LOAD,   8'd1,   8'd0,   8'hA5, 8'h5A, 8'h0F}, 1'b0, '0},
         '{'{OP_FILTER, 8'd0,   8'd0,   8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
         '{'{OP_UNUSED, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_SWAP,   8'd0,   8'd0,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_LOAD,   8'd255, 8'd0,   8'h12, 8'h34, 8'h56}, 1'b0, '0},
         '{'{OP_LOAD,   8'd1,   8'd0,   8'h80, 8'h01, 8'h7F}, 1'b0, '0},
         '{'{OP_LOAD,   8'd0,   8'd255, 8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
         '{'{OP_LOAD,   8'd0,   8'd1,   8'h00, 8'hFF, 8'h00}, 1'b0, '0},
         '{'{OP_FILTER, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
         '{'{OP_SWAP,   8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
         '{'{OP_FILTER, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00}, 1'b0, '0}
      };

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_word(directed[i].word, directed[i].typed, directed[i].want);

      // Random phases: free flow, idle sender, stalling receiver, both, then a hold-off
      for (int phase = 0; phase < 5; phase++) begin
         int target;
         send_idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 7 : 0;
         recv_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 7 : 0;
         if (phase == 4)
            hold_requests++;
         target = words_sent + PHASE_WORDS;
         while (words_sent < target)
            random_step();
      end
      req_valid <= 1'b0;

      // Drain, then let the block settle
      while (pending_averages.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d words (%0d filters, %0d swaps); checked %0d averaged pixels.",
               words_sent, filters_sent, swaps_sent, results_checked);
      $display("Covered wrapped corners, both frames, idle, stall and hold-off phases.");
      if (mismatches == 0)
         $display("[plus_stencil_torus_blur] OK");
      else
         $display("[plus_stencil_torus_blur] ERROR");
      $finish;
   end

endmodule
